@@ rtl/core/tsfr_pkg.sv @@
package tsfr_pkg;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int DIR_W  = 4;
	localparam int REG_W  = 4;

	// working widths of the datapath
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = 2 * DATA_W;
	localparam int FULL_W = 3 * DATA_W;

	// parameter defaults
	localparam int NUM_DIRECTIONS_DEF     = 16;
	localparam int FORWARD_DIRECTIONS_DEF = 8;
	localparam int NUM_REGIONS_DEF        = 16;
	localparam int FRAC_BITS_DEF          = 16;

	// saturation limits, by magnitude
	localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_SWEEP = 1'b1
	} cmd_t;

	// one coefficient table entry
	typedef struct packed {
		logic [DATA_W-1:0] coupling;
		logic [DATA_W-1:0] scale;
	} coef_t;

	// magnitude of a two's complement word, unsigned
	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
	endfunction

endpackage

@@ rtl/core/tsfr_if.sv @@
interface tsfr_in_if;
	logic                            valid;
	logic                            ready;
	tsfr_pkg::cmd_t                  cmd;
	logic [tsfr_pkg::DIR_W-1:0]      direction;
	logic [tsfr_pkg::REG_W-1:0]      region;
	logic signed [tsfr_pkg::DATA_W-1:0] coupling_coeff;
	logic signed [tsfr_pkg::DATA_W-1:0] scale_coeff;
	logic signed [tsfr_pkg::DATA_W-1:0] node_source;
	logic signed [tsfr_pkg::DATA_W-1:0] region_source;
	logic                            first_node;
	logic signed [tsfr_pkg::DATA_W-1:0] boundary_flux;

	modport source (
		output valid, cmd, direction, region, coupling_coeff, scale_coeff,
		       node_source, region_source, first_node, boundary_flux,
		input  ready
	);
	modport sink (
		input  valid, cmd, direction, region, coupling_coeff, scale_coeff,
		       node_source, region_source, first_node, boundary_flux,
		output ready
	);
endinterface

interface tsfr_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [tsfr_pkg::DATA_W-1:0] edge_flux;
	logic [tsfr_pkg::DIR_W-1:0]      out_direction;
	logic                            is_forward;
	logic                            saturated;

	modport source (
		output valid, edge_flux, out_direction, is_forward, saturated,
		input  ready
	);
	modport sink (
		input  valid, edge_flux, out_direction, is_forward, saturated,
		output ready
	);
endinterface

@@ rtl/core/tsfr_coef_mem.sv @@
module tsfr_coef_mem #(
	parameter int DEPTH = tsfr_pkg::NUM_REGIONS_DEF * tsfr_pkg::NUM_DIRECTIONS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tsfr_pkg::coef_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output tsfr_pkg::coef_t rdata
);

	tsfr_pkg::coef_t mem [DEPTH];
	tsfr_pkg::coef_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/tsfr_flux_mem.sv @@
module tsfr_flux_mem #(
	parameter int DEPTH = tsfr_pkg::NUM_DIRECTIONS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tsfr_pkg::DATA_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [tsfr_pkg::DATA_W-1:0] prior
);

	logic [tsfr_pkg::DATA_W-1:0] mem [DEPTH];
	logic [tsfr_pkg::DATA_W-1:0] rdata_q;
	logic [DEPTH-1:0]            valid_q;
	logic                        rvalid_q;

	// flux storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// per-direction written flags, a never-swept direction reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign prior = rvalid_q ? rdata_q : '0;

endmodule

@@ rtl/core/tsfr_mul.sv @@
module tsfr_mul (
	input  logic                        clk,
	input  logic [tsfr_pkg::DATA_W-1:0] a,
	input  logic [tsfr_pkg::DATA_W-1:0] b,
	output logic [tsfr_pkg::PROD_W-1:0] p
);

	logic [tsfr_pkg::PROD_W-1:0] p_q;

	// unsigned 32x32 product, registered
	always_ff @(posedge clk) begin
		p_q <= tsfr_pkg::PROD_W'(a) * tsfr_pkg::PROD_W'(b);
	end

	assign p = p_q;

endmodule

@@ rtl/core/transport_sweep_flux_recurrence.sv @@
// channel   | dir | handshake          | payload
// sweep_in  | in  | valid/ready        | cmd, direction, region, coeffs, sources, boundary
// flux_out  | out | valid/ready        | edge_flux, out_direction, is_forward, saturated
//
// a load item writes the table and leaves the input ready; a sweep item steps through
// read, sum, mul_lo, mul_hi and done before its result is registered, and the next
// transfer can follow in the cycle after that, with three passes through the shared
// 32x32 multiplier (coupling*prior, then the low and high halves of sum*scale).
// reset clears the control state and the per-direction flux flags, no clearing pass.
// input ready is high only while no sweep item is in work; a held result
// stalls the last step until the output register frees up.
module transport_sweep_flux_recurrence #(
	parameter int NUM_DIRECTIONS     = tsfr_pkg::NUM_DIRECTIONS_DEF,
	parameter int FORWARD_DIRECTIONS = tsfr_pkg::FORWARD_DIRECTIONS_DEF,
	parameter int NUM_REGIONS        = tsfr_pkg::NUM_REGIONS_DEF,
	parameter int FRAC_BITS          = tsfr_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tsfr_in_if.sink      sweep_in,
	tsfr_out_if.source   flux_out
);

	localparam int DW          = tsfr_pkg::DATA_W;
	localparam int TABLE_DEPTH = NUM_REGIONS * NUM_DIRECTIONS;
	localparam int COEF_AW     = $clog2(TABLE_DEPTH);
	localparam int DIR_AW      = $clog2(NUM_DIRECTIONS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DONE
	} state_t;

	state_t state_q;

	// item registers
	logic [tsfr_pkg::DIR_W-1:0] dir_q;
	logic [DW-1:0]              node_src_q;
	logic [DW-1:0]              region_src_q;
	logic                       first_q;
	logic [DW-1:0]              boundary_q;
	logic                       prod_neg_q;
	logic                       scale_neg_q;
	logic [DW-1:0]              scale_mag_q;
	logic [tsfr_pkg::SUM_W-1:0] sum_mag_q;
	logic                       res_neg_q;
	logic [tsfr_pkg::PROD_W-1:0] p_lo_q;

	// output register
	logic                       out_valid_q;
	logic [DW-1:0]              out_flux_q;
	logic [tsfr_pkg::DIR_W-1:0] out_dir_q;
	logic                       out_fwd_q;
	logic                       out_sat_q;

	logic                        accept;
	logic                        in_range;
	logic                        is_sweep;
	logic [COEF_AW-1:0]          coef_addr;
	logic [DIR_AW-1:0]           dir_idx;
	logic [DIR_AW-1:0]           dir_q_idx;
	tsfr_pkg::coef_t             coef_wdata;
	tsfr_pkg::coef_t             coef_rdata;
	logic                        coef_we;
	logic                        item_re;
	logic [DW-1:0]               flux_prior;
	logic [DW-1:0]               prior;
	logic [DW-1:0]               mul_a;
	logic [DW-1:0]               mul_b;
	logic [tsfr_pkg::PROD_W-1:0] mul_p;
	logic [tsfr_pkg::PROD_W-1:0] prod_shift;
	logic [tsfr_pkg::SUM_W-1:0]  prod_signed;
	logic [tsfr_pkg::SUM_W-1:0]  sum;
	logic [tsfr_pkg::SUM_W-1:0]  sum_mag;
	logic [tsfr_pkg::FULL_W-1:0] full_prod;
	logic [tsfr_pkg::FULL_W-1:0] full_shift;
	logic [DW-1:0]               limit;
	logic                        sat;
	logic [DW-1:0]               res_mag;
	logic [DW-1:0]               res;
	logic                        out_free;
	logic                        flux_we;
	logic                        fwd;

	// input decode
	assign sweep_in.ready = (state_q == ST_IDLE);
	assign accept   = sweep_in.valid && sweep_in.ready;
	assign in_range = (32'(sweep_in.direction) < 32'(NUM_DIRECTIONS))
	               && (32'(sweep_in.region) < 32'(NUM_REGIONS));
	assign is_sweep = (sweep_in.cmd == tsfr_pkg::CMD_SWEEP);
	assign coef_addr = COEF_AW'(32'(sweep_in.region) * 32'(NUM_DIRECTIONS)
	                 + 32'(sweep_in.direction));
	assign dir_idx   = DIR_AW'(sweep_in.direction);
	assign dir_q_idx = DIR_AW'(dir_q);
	assign coef_we   = accept && in_range && !is_sweep;
	assign item_re   = accept && in_range && is_sweep;
	assign coef_wdata.coupling = sweep_in.coupling_coeff;
	assign coef_wdata.scale    = sweep_in.scale_coeff;

	tsfr_coef_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (COEF_AW)
	) u_coef_mem (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_addr),
		.wdata (coef_wdata),
		.re    (item_re),
		.raddr (coef_addr),
		.rdata (coef_rdata)
	);

	tsfr_flux_mem #(
		.DEPTH (NUM_DIRECTIONS),
		.AW    (DIR_AW)
	) u_flux_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (flux_we),
		.waddr  (dir_q_idx),
		.wdata  (res),
		.re     (item_re),
		.raddr  (dir_idx),
		.prior  (flux_prior)
	);

	// prior flux choice
	assign prior = first_q ? boundary_q : flux_prior;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_READ: begin
				mul_a = tsfr_pkg::mag32(coef_rdata.coupling);
				mul_b = tsfr_pkg::mag32(prior);
			end
			ST_MUL_LO: begin
				mul_a = sum_mag_q[DW-1:0];
				mul_b = scale_mag_q;
			end
			default: begin
				mul_a = sum_mag_q[2*DW-1:DW];
				mul_b = scale_mag_q;
			end
		endcase
	end

	tsfr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// source sum minus truncated coupling product
	assign prod_shift  = mul_p >> FRAC_BITS;
	assign prod_signed = prod_neg_q ? (~prod_shift + tsfr_pkg::SUM_W'(1)) : prod_shift;
	assign sum = {{DW{node_src_q[DW-1]}}, node_src_q}
	           + {{DW{region_src_q[DW-1]}}, region_src_q}
	           - prod_signed;
	assign sum_mag = sum[tsfr_pkg::SUM_W-1] ? (~sum + tsfr_pkg::SUM_W'(1)) : sum;

	// combine partial products, shift and saturate
	assign full_prod  = {mul_p, {DW{1'b0}}} + tsfr_pkg::FULL_W'(p_lo_q);
	assign full_shift = full_prod >> FRAC_BITS;
	assign limit      = res_neg_q ? tsfr_pkg::NEG_LIMIT : tsfr_pkg::POS_LIMIT;
	assign sat        = (|full_shift[tsfr_pkg::FULL_W-1:DW]) || (full_shift[DW-1:0] > limit);
	assign res_mag    = sat ? limit : full_shift[DW-1:0];
	assign res        = res_neg_q ? (~res_mag + DW'(1)) : res_mag;
	assign fwd        = 32'(dir_q) < 32'(FORWARD_DIRECTIONS);

	// output register handoff
	assign out_free = !out_valid_q || flux_out.ready;
	assign flux_we  = (state_q == ST_DONE) && out_free;

	// sequencer, item registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dir_q        <= '0;
			node_src_q   <= '0;
			region_src_q <= '0;
			first_q      <= 1'b0;
			boundary_q   <= '0;
			prod_neg_q   <= 1'b0;
			scale_neg_q  <= 1'b0;
			scale_mag_q  <= '0;
			sum_mag_q    <= '0;
			res_neg_q    <= 1'b0;
			p_lo_q       <= '0;
			out_valid_q  <= 1'b0;
			out_flux_q   <= '0;
			out_dir_q    <= '0;
			out_fwd_q    <= 1'b0;
			out_sat_q    <= 1'b0;
		end else begin
			if (out_valid_q && flux_out.ready && !flux_we) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_re) begin
						dir_q        <= sweep_in.direction;
						node_src_q   <= sweep_in.node_source;
						region_src_q <= sweep_in.region_source;
						first_q      <= sweep_in.first_node;
						boundary_q   <= sweep_in.boundary_flux;
						state_q      <= ST_READ;
					end
				end
				ST_READ: begin
					prod_neg_q  <= coef_rdata.coupling[DW-1] ^ prior[DW-1];
					scale_neg_q <= coef_rdata.scale[DW-1];
					scale_mag_q <= tsfr_pkg::mag32(coef_rdata.scale);
					state_q     <= ST_SUM;
				end
				ST_SUM: begin
					sum_mag_q <= sum_mag;
					res_neg_q <= sum[tsfr_pkg::SUM_W-1] ^ scale_neg_q;
					state_q   <= ST_MUL_LO;
				end
				ST_MUL_LO: begin
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					p_lo_q  <= mul_p;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_flux_q  <= res;
						out_dir_q   <= dir_q;
						out_fwd_q   <= fwd;
						out_sat_q   <= sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign flux_out.valid         = out_valid_q;
	assign flux_out.edge_flux     = out_flux_q;
	assign flux_out.out_direction = out_dir_q;
	assign flux_out.is_forward    = out_fwd_q;
	assign flux_out.saturated     = out_sat_q;

endmodule

@@ rtl/core/tsfr_checker.sv @@
module tsfr_checker #(
	parameter int NUM_DIRECTIONS     = tsfr_pkg::NUM_DIRECTIONS_DEF,
	parameter int FORWARD_DIRECTIONS = tsfr_pkg::FORWARD_DIRECTIONS_DEF,
	parameter int NUM_REGIONS        = tsfr_pkg::NUM_REGIONS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input tsfr_pkg::cmd_t                in_cmd,
	input logic [tsfr_pkg::DIR_W-1:0]    in_direction,
	input logic [tsfr_pkg::REG_W-1:0]    in_region,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tsfr_pkg::DATA_W-1:0]   out_edge_flux,
	input logic [tsfr_pkg::DIR_W-1:0]    out_direction,
	input logic                          out_is_forward,
	input logic                          out_saturated
);

	logic sweep_xfer;

	assign sweep_xfer = in_valid && in_ready && (in_cmd == tsfr_pkg::CMD_SWEEP)
	                 && (32'(in_direction) < 32'(NUM_DIRECTIONS))
	                 && (32'(in_region) < 32'(NUM_REGIONS));

	// a held result stays put until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_edge_flux)
		&& $stable(out_direction) && $stable(out_saturated))
		else $error("result changed while stalled");

	// a clipped result sits at one of the two limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_saturated |->
		(out_edge_flux == tsfr_pkg::POS_LIMIT) || (out_edge_flux == tsfr_pkg::NEG_LIMIT))
		else $error("saturated result not at a limit");

	// forward flag follows the direction
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_is_forward == (32'(out_direction) < 32'(FORWARD_DIRECTIONS)))
		else $error("forward flag does not match direction");

	// a sweep item in work blocks the next transfer
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_xfer |=> !in_ready ##1 !in_ready)
		else $error("input taken during sweep step");

endmodule

bind transport_sweep_flux_recurrence tsfr_checker #(
	.NUM_DIRECTIONS     (NUM_DIRECTIONS),
	.FORWARD_DIRECTIONS (FORWARD_DIRECTIONS),
	.NUM_REGIONS        (NUM_REGIONS)
) u_tsfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sweep_in.valid),
	.in_ready       (sweep_in.ready),
	.in_cmd         (sweep_in.cmd),
	.in_direction   (sweep_in.direction),
	.in_region      (sweep_in.region),
	.out_valid      (flux_out.valid),
	.out_ready      (flux_out.ready),
	.out_edge_flux  (flux_out.edge_flux),
	.out_direction  (flux_out.out_direction),
	.out_is_forward (flux_out.is_forward),
	.out_saturated  (flux_out.saturated)
);

@@ verif/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_DIRS     = tsfr_pkg::NUM_DIRECTIONS_DEF;
	localparam int FWD_DIRS     = tsfr_pkg::FORWARD_DIRECTIONS_DEF;
	localparam int REGION_CNT   = tsfr_pkg::NUM_REGIONS_DEF;
	localparam int FRAC         = tsfr_pkg::FRAC_BITS_DEF;
	localparam int TBL_DEPTH    = REGION_CNT * NUM_DIRS;
	localparam int ITEM_TARGET  = 700;
	localparam int LONG_HOLD    = 120;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 24;

	typedef logic signed [tsfr_pkg::DATA_W-1:0] q_t;

	localparam q_t Q_ONE  = 32'h0001_0000;
	localparam q_t Q_HALF = 32'h0000_8000;
	localparam q_t Q_MAX  = 32'h7fff_ffff;
	localparam q_t Q_MIN  = 32'h8000_0000;

	typedef struct {
		tsfr_pkg::cmd_t             cmd;
		logic [tsfr_pkg::DIR_W-1:0] direction;
		logic [tsfr_pkg::REG_W-1:0] region;
		q_t                         coupling_coeff;
		q_t                         scale_coeff;
		q_t                         node_source;
		q_t                         region_source;
		logic                       first_node;
		q_t                         boundary_flux;
	} sweep_item_t;

	typedef struct {
		q_t                         edge_flux;
		logic [tsfr_pkg::DIR_W-1:0] out_direction;
		logic                       is_forward;
		logic                       saturated;
	} flux_res_t;

	typedef struct {
		bit        known;
		flux_res_t res;
	} typed_res_t;

	typedef struct {
		sweep_item_t item;
		typed_res_t  exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tsfr_in_if  sweep_if ();
	tsfr_out_if flux_if ();

	transport_sweep_flux_recurrence dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sweep_in (sweep_if),
		.flux_out (flux_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: per-direction prior flux and coefficient tables
	q_t prior_flux   [NUM_DIRS];
	q_t coupling_mem [TBL_DEPTH];
	q_t scale_mem    [TBL_DEPTH];

	flux_res_t  pending_flux_q [$];
	typed_res_t typed_flux_q [$];
	bit         coef_loaded [TBL_DEPTH];

	int  mismatches = 0;
	int  items_sent = 0;
	int  n_loads = 0;
	int  n_sweeps = 0;
	int  n_boundary = 0;
	int  n_sat = 0;
	bit  quiet = 1'b0;
	bit  hold_off_req = 1'b0;

	// exact product, shifted down and truncated toward zero by magnitude
	function automatic logic signed [63:0] trunc_product(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0] ma, mb, m;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		m = (ma * mb) >> FRAC;
		return (a[63] ^ b[63]) ? -$signed(m) : $signed(m);
	endfunction

	// one sweep step: updates tables or prior flux, returns 1 when a result is due
	function automatic bit sweep_step(input sweep_item_t it, output flux_res_t res);
		int unsigned idx;
		logic signed [63:0] prior, sum, scl;
		logic [127:0] mag_sum, mag_scl, mag_res, limit;
		logic neg;
		res = '{default: '0};
		if (it.direction >= NUM_DIRS || it.region >= REGION_CNT) return 1'b0;
		idx = it.region * NUM_DIRS + it.direction;
		if (it.cmd == tsfr_pkg::CMD_LOAD) begin
			coupling_mem[idx] = it.coupling_coeff;
			scale_mem[idx] = it.scale_coeff;
			return 1'b0;
		end
		prior = it.first_node ? 64'(it.boundary_flux) : 64'(prior_flux[it.direction]);
		sum = 64'(it.node_source) + 64'(it.region_source)
			- trunc_product(64'(coupling_mem[idx]), prior);
		scl = 64'(scale_mem[idx]);
		neg = sum[63] ^ scl[63];
		mag_sum = sum[63] ? 128'(-sum) : 128'(sum);
		mag_scl = scl[63] ? 128'(-scl) : 128'(scl);
		mag_res = (mag_sum * mag_scl) >> FRAC;
		limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		res.saturated = mag_res > limit;
		if (res.saturated) mag_res = limit;
		res.edge_flux = neg ? q_t'(~mag_res[31:0] + 32'd1) : q_t'(mag_res[31:0]);
		res.out_direction = it.direction;
		res.is_forward = it.direction < FWD_DIRS;
		prior_flux[it.direction] = res.edge_flux;
		return 1'b1;
	endfunction

	// mostly short gaps, a few long ones, none in quiet stretches
	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// value within +-span most of the time, else full range or an extreme
	function automatic q_t rand_q(input int unsigned span);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return q_t'($signed($urandom_range(0, 2 * span)) - $signed(span));
		if (r < 9) return q_t'($urandom);
		unique case ($urandom_range(0, 4))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return Q_ONE;
			default: return '1;
		endcase
	endfunction

	function automatic stim_row_t load_row(input int dir, input int rgn, input q_t cpl,
			input q_t scl);
		stim_row_t row;
		row.item.cmd = tsfr_pkg::CMD_LOAD;
		row.item.direction = tsfr_pkg::DIR_W'(dir);
		row.item.region = tsfr_pkg::REG_W'(rgn);
		row.item.coupling_coeff = cpl;
		row.item.scale_coeff = scl;
		row.item.node_source = q_t'($urandom);
		row.item.region_source = q_t'($urandom);
		row.item.first_node = 1'($urandom_range(0, 1));
		row.item.boundary_flux = q_t'($urandom);
		row.exp.known = 1'b0;
		return row;
	endfunction

	function automatic stim_row_t sweep_row(input int dir, input int rgn, input bit lead,
			input q_t bnd, input q_t ns, input q_t rs);
		stim_row_t row;
		row.item.cmd = tsfr_pkg::CMD_SWEEP;
		row.item.direction = tsfr_pkg::DIR_W'(dir);
		row.item.region = tsfr_pkg::REG_W'(rgn);
		row.item.coupling_coeff = q_t'($urandom);
		row.item.scale_coeff = q_t'($urandom);
		row.item.node_source = ns;
		row.item.region_source = rs;
		row.item.first_node = lead;
		row.item.boundary_flux = bnd;
		row.exp.known = 1'b0;
		return row;
	endfunction

	// attach a result that is known by inspection
	function automatic stim_row_t with_result(input stim_row_t row, input q_t flux,
			input bit sat);
		row.exp.known = 1'b1;
		row.exp.res.edge_flux = flux;
		row.exp.res.out_direction = row.item.direction;
		row.exp.res.is_forward = row.item.direction < FWD_DIRS;
		row.exp.res.saturated = sat;
		return row;
	endfunction

	// drive one item after a random gap and hold it until the transfer
	task automatic send_item(input stim_row_t row);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			sweep_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		typed_flux_q.push_back(row.exp);
		sweep_if.cmd            <= row.item.cmd;
		sweep_if.direction      <= row.item.direction;
		sweep_if.region         <= row.item.region;
		sweep_if.coupling_coeff <= row.item.coupling_coeff;
		sweep_if.scale_coeff    <= row.item.scale_coeff;
		sweep_if.node_source    <= row.item.node_source;
		sweep_if.region_source  <= row.item.region_source;
		sweep_if.first_node     <= row.item.first_node;
		sweep_if.boundary_flux  <= row.item.boundary_flux;
		sweep_if.valid          <= 1'b1;
		do @(posedge clk); while (!sweep_if.ready);
		if (row.item.cmd == tsfr_pkg::CMD_LOAD)
			coef_loaded[row.item.region * NUM_DIRS + row.item.direction] = 1'b1;
		items_sent++;
	endtask

	// input side: predict each transferred item
	always @(posedge clk) begin : sweep_in_monitor
		sweep_item_t it;
		flux_res_t   res;
		typed_res_t  typed;
		if (arst_n && sweep_if.valid && sweep_if.ready) begin
			it.cmd            = sweep_if.cmd;
			it.direction      = sweep_if.direction;
			it.region         = sweep_if.region;
			it.coupling_coeff = sweep_if.coupling_coeff;
			it.scale_coeff    = sweep_if.scale_coeff;
			it.node_source    = sweep_if.node_source;
			it.region_source  = sweep_if.region_source;
			it.first_node     = sweep_if.first_node;
			it.boundary_flux  = sweep_if.boundary_flux;
			typed = typed_flux_q.pop_front();
			if (it.cmd == tsfr_pkg::CMD_LOAD) n_loads++;
			if (sweep_step(it, res)) begin
				n_sweeps++;
				if (it.first_node) n_boundary++;
				if (res.saturated) n_sat++;
				pending_flux_q.push_back(typed.known ? typed.res : res);
			end
		end
	end

	// output side: compare each transfer with the oldest expectation
	always @(posedge clk) begin : flux_out_check
		flux_res_t want;
		if (arst_n && flux_if.valid && flux_if.ready) begin
			if (pending_flux_q.size() == 0) begin
				$error("unexpected result: edge_flux %h out_direction %0d",
					flux_if.edge_flux, flux_if.out_direction);
				mismatches++;
			end else begin
				want = pending_flux_q.pop_front();
				if (flux_if.edge_flux !== want.edge_flux) begin
					$error("edge_flux: expected %h, actual %h", want.edge_flux,
						flux_if.edge_flux);
					mismatches++;
				end
				if (flux_if.out_direction !== want.out_direction) begin
					$error("out_direction: expected %0d, actual %0d", want.out_direction,
						flux_if.out_direction);
					mismatches++;
				end
				if (flux_if.is_forward !== want.is_forward) begin
					$error("is_forward: expected %b, actual %b", want.is_forward,
						flux_if.is_forward);
					mismatches++;
				end
				if (flux_if.saturated !== want.saturated) begin
					$error("saturated: expected %b, actual %b", want.saturated,
						flux_if.saturated);
					mismatches++;
				end
			end
		end
	end

	// result receiver with random stalls and one long hold-off on request
	initial begin : flux_receiver
		int stall;
		stall = 0;
		flux_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = LONG_HOLD;
			end else if (stall == 0 && !quiet && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				flux_if.ready <= 1'b0;
				stall--;
			end else begin
				flux_if.ready <= 1'b1;
			end
		end
	end

	// give up when no transfer happens for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((sweep_if.valid && sweep_if.ready) || (flux_if.valid && flux_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("** transport_sweep_flux_recurrence: FAILED **");
		$finish;
	end

	initial begin : stimulus
		stim_row_t rows [$];
		int dir, rgn, run_len, k, idx;
		bit broken, lead, held, drained;

		held = 1'b0;
		drained = 1'b0;
		sweep_if.valid          = 1'b0;
		sweep_if.cmd            = tsfr_pkg::CMD_LOAD;
		sweep_if.direction      = '0;
		sweep_if.region         = '0;
		sweep_if.coupling_coeff = '0;
		sweep_if.scale_coeff    = '0;
		sweep_if.node_source    = '0;
		sweep_if.region_source  = '0;
		sweep_if.first_node     = 1'b0;
		sweep_if.boundary_flux  = '0;
		foreach (prior_flux[i]) prior_flux[i] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed rows: unit coefficients, prior after reset, chained prior
		rows.push_back(load_row(0, 0, Q_ONE, Q_ONE));
		rows.push_back(with_result(sweep_row(0, 0, 1'b0, Q_MAX, Q_ONE, 2 * Q_ONE),
			32'h0003_0000, 1'b0));
		rows.push_back(with_result(sweep_row(0, 0, 1'b0, Q_MIN, '0, '0), 32'hfffd_0000,
			1'b0));
		// extreme coefficients and sources, clipped both ways
		rows.push_back(load_row(15, 15, Q_MAX, Q_MAX));
		rows.push_back(with_result(sweep_row(15, 15, 1'b1, Q_MIN, Q_MAX, Q_MAX), Q_MAX,
			1'b1));
		rows.push_back(load_row(8, 15, Q_MIN, Q_MIN));
		rows.push_back(with_result(sweep_row(8, 15, 1'b1, Q_MAX, Q_MIN, Q_MIN), Q_MIN,
			1'b1));
		// unclipped intermediate sum beyond 32 bits
		rows.push_back(load_row(7, 7, '0, Q_ONE));
		rows.push_back(with_result(sweep_row(7, 7, 1'b1, 32'h1234_5678, Q_MAX, Q_MAX),
			Q_MAX, 1'b1));
		// truncation toward zero on negative products
		rows.push_back(load_row(2, 3, '0, Q_HALF));
		rows.push_back(with_result(sweep_row(2, 3, 1'b0, '0, -32'sd1, '0), '0, 1'b0));
		rows.push_back(with_result(sweep_row(2, 3, 1'b0, '0, -32'sd3, '0), -32'sd1, 1'b0));
		// most negative value reached exactly, not clipped
		rows.push_back(load_row(9, 3, '0, Q_ONE));
		rows.push_back(with_result(sweep_row(9, 3, 1'b0, Q_MAX, Q_MIN, '0), Q_MIN, 1'b0));
		// priors left by clipped results, checked by the predictor
		rows.push_back(sweep_row(15, 15, 1'b0, '0, 32'h0001_2345, -32'sh0000_4321));
		rows.push_back(sweep_row(8, 15, 1'b0, '0, '0, Q_ONE));
		// coefficient overwrite, then boundary restart
		rows.push_back(load_row(0, 0, Q_HALF, 32'h0001_8000));
		rows.push_back(sweep_row(0, 0, 1'b0, '0, 32'h0000_1234, -32'sh0000_5678));
		rows.push_back(sweep_row(0, 0, 1'b1, Q_MAX, '0, '0));
		rows.push_back(load_row(4, 1, rand_q(32'h1_8000), rand_q(32'h2_0000)));
		rows.push_back(sweep_row(4, 1, 1'b0, Q_MIN, rand_q(32'h4_0000), rand_q(32'h4_0000)));
		rows.push_back(sweep_row(4, 1, 1'b0, '0, Q_MAX, Q_MIN));
		rows.push_back(with_result(sweep_row(7, 7, 1'b0, Q_MAX, Q_MIN, Q_MIN), Q_MIN, 1'b1));
		foreach (rows[i]) send_item(rows[i]);

		// random sweeps: one direction per run, most runs starting from the boundary
		while (items_sent < ITEM_TARGET) begin
			dir = $urandom_range(0, NUM_DIRS - 1);
			run_len = $urandom_range(1, 10);
			broken = $urandom_range(0, 9) == 0;
			for (k = 0; k < run_len; k++) begin
				rgn = $urandom_range(0, REGION_CNT - 1);
				idx = rgn * NUM_DIRS + dir;
				if (!coef_loaded[idx] || $urandom_range(0, 11) == 0)
					send_item(load_row(dir, rgn, rand_q(32'h1_8000), rand_q(32'h2_0000)));
				lead = (k == 0) ? !broken : ($urandom_range(0, 24) == 0);
				send_item(sweep_row(dir, rgn, lead, rand_q(32'h4_0000),
					rand_q(32'h4_0000), rand_q(32'h4_0000)));
			end
			quiet = items_sent >= 450 && items_sent < 560;
			// long output hold-off while the sender keeps offering
			if (!held && items_sent >= 150) begin
				held = 1'b1;
				hold_off_req = 1'b1;
			end
			// sender pause until the pipeline drains
			if (!drained && items_sent >= 350) begin
				drained = 1'b1;
				@(negedge clk) sweep_if.valid <= 1'b0;
				wait (pending_flux_q.size() == 0);
			end
		end
		quiet = 1'b0;

		@(negedge clk) sweep_if.valid <= 1'b0;
		wait (pending_flux_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("coverage: %0d coefficient loads, %0d sweep nodes, %0d from boundary flux",
			n_loads, n_sweeps, n_boundary);
		$display("coverage: %0d clipped results, one %0d-cycle output hold-off",
			n_sat, LONG_HOLD);
		if (mismatches == 0 && pending_flux_q.size() == 0)
			$display("** transport_sweep_flux_recurrence: PASSED **");
		else
			$display("** transport_sweep_flux_recurrence: FAILED **");
		$finish;
	end

endmodule
